// ----- sv/bcd_pkg.sv -----
// Shared types and constants of the bit change detector.
`default_nettype none
package bcd_pkg;

  localparam int BYTE_W  = 8;
  localparam int IDX_W   = 12;
  localparam int BIT_W   = 3;
  localparam int BITNO_W = IDX_W + BIT_W;
  localparam int CNT_W   = 16;
  localparam int LEN_W   = 13;
  localparam int CMPW    = 17;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam logic [BIT_W-1:0] BIT_LAST = '1;

  localparam logic CMD_COMPARE  = 1'b0;
  localparam logic CMD_REBASE   = 1'b1;
  localparam logic KIND_CHANGE  = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_READ = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_SUM  = 4'b1000
  } state_t;

endpackage
`default_nettype wire

// ----- sv/bcd_ram.sv -----
// Generic simple dual-port RAM with registered read.
`default_nettype none
module bcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- sv/bit_change_detector.sv -----
// Bit change detector: compares byte snapshots against a stored copy, bit by bit.
//
// Input channel (in_valid / in_stall): one snapshot byte per word with its
// command and byte index. Output channel (out_valid / out_stall): one word per
// changed bit, low bit first, with a running change count, plus a summary word
// on the last byte of a snapshot. cfg_write / cfg_data set the snapshot length.
// A compare byte passes from acceptance through a store read state and then
// through the one-bit compare and shift unit, one bit a step over eight bits;
// the last byte of a snapshot adds a summary state. The next byte is accepted
// only after the scan, and any summary, has ended. Baseline bytes are written
// to the store at acceptance; the last one adds a zero summary.
// Bytes whose index lies beyond the snapshot length are dropped.
// A stall on the output holds the pending word and freezes the bit scan at a changed
// bit; in_stall stays high until the current byte's scan and summary are done.
// Reset clears the baseline flag and the change count and sets the length to
// 4096; the store contents are undefined until a baseline pass writes them.
`default_nettype none
module bit_change_detector #(
  parameter int MAX_BYTES = 4096
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_write,
  input  wire logic [bcd_pkg::LEN_W-1:0]       cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic                            command,
  input  wire logic [bcd_pkg::IDX_W-1:0]       byte_index,
  input  wire logic [bcd_pkg::BYTE_W-1:0]      data_byte,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic                                 kind,
  output logic [bcd_pkg::BITNO_W-1:0]          bit_index,
  output logic                                 old_bit,
  output logic                                 new_bit,
  output logic [bcd_pkg::CNT_W-1:0]            change_count,
  output logic                                 last_result
);

  localparam int AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam logic [bcd_pkg::CMPW-1:0] MAX_LEN = bcd_pkg::CMPW'(MAX_BYTES);

  bcd_pkg::state_t state;

  logic [bcd_pkg::LEN_W-1:0]  snapshot_bytes;
  logic                       baseline_valid;
  logic [bcd_pkg::CNT_W-1:0]  pass_count;
  logic [bcd_pkg::IDX_W-1:0]  idx;
  logic [bcd_pkg::BYTE_W-1:0] cur;
  logic [bcd_pkg::BYTE_W-1:0] old_sh;
  logic [bcd_pkg::BYTE_W-1:0] new_sh;
  logic [bcd_pkg::BIT_W-1:0]  bit_cnt;
  logic                       last_byte;

  logic [bcd_pkg::CMPW-1:0]   cfg_ext;
  logic [bcd_pkg::CMPW-1:0]   len_eff;
  logic [bcd_pkg::CMPW-1:0]   idx_ext;
  logic [31:0]                addr_ext;
  logic [31:0]                idx_addr_ext;
  logic [AW-1:0]              addr;
  logic                       in_range;
  logic                       is_last;
  logic                       accept;
  logic                       base_hit;
  logic                       cmp_hit;
  logic                       out_free;
  logic                       diff0;
  logic                       rest_same;
  logic                       emit_chg;
  logic                       advance;
  logic                       emit_sum;
  logic [bcd_pkg::CNT_W-1:0]  cnt_inc;

  logic                       ram_we;
  logic [AW-1:0]              ram_waddr;
  logic [bcd_pkg::BYTE_W-1:0] ram_wdata;
  logic [bcd_pkg::BYTE_W-1:0] ram_rdata;

  assign cfg_ext  = bcd_pkg::CMPW'(snapshot_bytes);
  assign len_eff  = (cfg_ext == '0) ? bcd_pkg::CMPW'(1) :
                    (cfg_ext > MAX_LEN) ? MAX_LEN : cfg_ext;
  assign idx_ext  = bcd_pkg::CMPW'(byte_index);
  assign in_range = idx_ext < len_eff;
  assign is_last  = idx_ext == (len_eff - bcd_pkg::CMPW'(1));
  assign addr_ext = 32'(byte_index);
  assign addr     = addr_ext[AW-1:0];
  assign idx_addr_ext = 32'(idx);

  assign in_stall = (state != bcd_pkg::ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign base_hit = accept && in_range &&
                    (command == bcd_pkg::CMD_REBASE || !baseline_valid);
  assign cmp_hit  = accept && in_range &&
                    command == bcd_pkg::CMD_COMPARE && baseline_valid;

  assign out_free  = !out_valid || !out_stall;
  assign diff0     = old_sh[0] ^ new_sh[0];
  assign rest_same = (old_sh[bcd_pkg::BYTE_W-1:1] ^ new_sh[bcd_pkg::BYTE_W-1:1]) == '0;
  assign emit_chg  = (state == bcd_pkg::ST_SCAN) && diff0 && out_free;
  assign advance   = (state == bcd_pkg::ST_SCAN) && (!diff0 || out_free);
  assign emit_sum  = (state == bcd_pkg::ST_SUM) && out_free;
  assign cnt_inc   = (pass_count == bcd_pkg::CNT_MAX) ? pass_count
                                                      : pass_count + 1'b1;

  // Store write: baseline bytes at acceptance, compare bytes after the read.
  assign ram_we    = base_hit || (state == bcd_pkg::ST_READ);
  assign ram_waddr = base_hit ? addr : idx_addr_ext[AW-1:0];
  assign ram_wdata = base_hit ? data_byte : cur;

  bcd_ram #(
    .WIDTH(bcd_pkg::BYTE_W),
    .DEPTH(MAX_BYTES)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(addr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= bcd_pkg::ST_IDLE;
      snapshot_bytes <= bcd_pkg::LEN_W'(4096);
      baseline_valid <= 1'b0;
      pass_count     <= '0;
      bit_cnt        <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_write) begin
        snapshot_bytes <= cfg_data;
      end
      if (emit_chg || emit_sum) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        bcd_pkg::ST_IDLE: begin
          if (base_hit) begin
            pass_count <= '0;
            if (is_last) begin
              baseline_valid <= 1'b1;
              state          <= bcd_pkg::ST_SUM;
            end
          end else if (cmp_hit) begin
            state <= bcd_pkg::ST_READ;
          end
        end
        bcd_pkg::ST_READ: begin
          bit_cnt <= '0;
          state   <= bcd_pkg::ST_SCAN;
        end
        bcd_pkg::ST_SCAN: begin
          if (emit_chg) begin
            pass_count <= cnt_inc;
          end
          if (advance) begin
            bit_cnt <= bit_cnt + 1'b1;
            if (bit_cnt == bcd_pkg::BIT_LAST) begin
              state <= last_byte ? bcd_pkg::ST_SUM : bcd_pkg::ST_IDLE;
            end
          end
        end
        bcd_pkg::ST_SUM: begin
          if (emit_sum) begin
            pass_count <= '0;
            state      <= bcd_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= bcd_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // Payload registers: latch the byte, load the shift unit, shift one bit a step.
  always_ff @(posedge clk) begin
    if (accept) begin
      idx       <= byte_index;
      cur       <= data_byte;
      last_byte <= is_last;
    end
    if (state == bcd_pkg::ST_READ) begin
      old_sh <= ram_rdata;
      new_sh <= cur;
    end else if (advance) begin
      old_sh <= old_sh >> 1;
      new_sh <= new_sh >> 1;
    end
    if (emit_chg) begin
      kind         <= bcd_pkg::KIND_CHANGE;
      bit_index    <= {idx, bit_cnt};
      old_bit      <= old_sh[0];
      new_bit      <= new_sh[0];
      change_count <= cnt_inc;
      last_result  <= !last_byte && rest_same;
    end else if (emit_sum) begin
      kind         <= bcd_pkg::KIND_SUMMARY;
      bit_index    <= '0;
      old_bit      <= 1'b0;
      new_bit      <= 1'b0;
      change_count <= pass_count;
      last_result  <= 1'b1;
    end
  end

  a_sum_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == bcd_pkg::KIND_SUMMARY |-> last_result)
    else $error("summary word without last mark");

  a_sum_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == bcd_pkg::KIND_SUMMARY |-> bit_index == '0 && !old_bit && !new_bit)
    else $error("summary word carries bit fields");

  a_chg_diff: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == bcd_pkg::KIND_CHANGE |-> old_bit != new_bit)
    else $error("change word with equal bits");

  a_chg_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == bcd_pkg::KIND_CHANGE |-> change_count != '0)
    else $error("change word with zero count");

  a_scan_busy: assert property (@(posedge clk) disable iff (rst)
    cmp_hit |=> in_stall ##1 in_stall)
    else $error("input accepted during compare scan");

endmodule
`default_nettype wire

// ----- verif/testbench.sv -----
// Self-checking testbench for the bit change detector: random-gap driver, stalling monitor, predictor.
`timescale 1ns / 100ps
module testbench;

  localparam int STORE_DEPTH   = 4096;
  localparam int RANDOM_ITEMS  = 150;
  localparam int SETTLE_CYCLES = 24;
  localparam int CYCLE_LIMIT   = 10_000_000;

  typedef struct packed {
    logic                        kind;
    logic [bcd_pkg::BITNO_W-1:0] bit_index;
    logic                        old_bit;
    logic                        new_bit;
    logic [bcd_pkg::CNT_W-1:0]   change_count;
    logic                        last_result;
  } change_word_t;

  typedef struct {
    bit                        cmd;
    bit [bcd_pkg::IDX_W-1:0]   idx;
    bit [bcd_pkg::BYTE_W-1:0]  data;
  } snap_byte_t;

  logic                         clk;
  logic                         rst;
  logic                         cfg_write;
  logic [bcd_pkg::LEN_W-1:0]    cfg_data;
  logic                         in_valid;
  logic                         in_stall;
  logic                         command;
  logic [bcd_pkg::IDX_W-1:0]    byte_index;
  logic [bcd_pkg::BYTE_W-1:0]   data_byte;
  logic                         out_valid;
  logic                         out_stall;
  logic                         kind;
  logic [bcd_pkg::BITNO_W-1:0]  bit_index;
  logic                         old_bit;
  logic                         new_bit;
  logic [bcd_pkg::CNT_W-1:0]    change_count;
  logic                         last_result;

  bit_change_detector DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .command      (command),
    .byte_index   (byte_index),
    .data_byte    (data_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .bit_index    (bit_index),
    .old_bit      (old_bit),
    .new_bit      (new_bit),
    .change_count (change_count),
    .last_result  (last_result)
  );

  snap_byte_t    byte_feed[$];
  change_word_t  predicted_words[$];

  bit [bcd_pkg::LEN_W-1:0]   cur_len = bcd_pkg::LEN_W'(STORE_DEPTH);
  bit [bcd_pkg::BYTE_W-1:0]  shadow_store [STORE_DEPTH];
  bit                        shadow_baseline;
  bit [bcd_pkg::CNT_W-1:0]   shadow_count;

  bit [bcd_pkg::BYTE_W-1:0]  feed_value [STORE_DEPTH];
  bit                        feed_written [STORE_DEPTH];
  bit                        feed_baseline;

  bit  calm;
  int  gap_left;
  int  stall_left;
  int  cycles;
  int  mismatches;
  int  useful_sent;
  int  len_writes;
  int  words_checked;
  int  summaries_seen;
  int  top_total;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int clamp_len(input bit [bcd_pkg::LEN_W-1:0] v);
    if (v == 0) return 1;
    if (v > STORE_DEPTH) return STORE_DEPTH;
    return int'(v);
  endfunction

  function automatic int pick_idle();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 25) : $urandom_range(1, 3);
  endfunction

  function automatic bit [bcd_pkg::BYTE_W-1:0] nudge_byte(input bit [bcd_pkg::BYTE_W-1:0] v);
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return v;
    if (r < 6) return v ^ (8'h01 << $urandom_range(0, 7));
    if (r < 8) return bcd_pkg::BYTE_W'($urandom);
    if (r == 8) return ~v;
    return v ^ bcd_pkg::BYTE_W'($urandom);
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("ERROR @%0t: %s", $time, what);
  endtask

  task automatic queue_word(input change_word_t w);
    predicted_words = {predicted_words, w};
  endtask

  task automatic predict_bit_changes(input bit cmd, input bit [bcd_pkg::IDX_W-1:0] idx,
                                     input bit [bcd_pkg::BYTE_W-1:0] now);
    change_word_t              w;
    bit [bcd_pkg::BYTE_W-1:0]  diff;
    int                        span;
    int                        left;
    span = clamp_len(cur_len);
    if (idx >= span) return;
    if (cmd == bcd_pkg::CMD_REBASE || !shadow_baseline) begin
      shadow_store[idx] = now;
      shadow_count = '0;
      if (idx == span - 1) begin
        shadow_baseline = 1'b1;
        w = '0;
        w.kind = bcd_pkg::KIND_SUMMARY;
        w.last_result = 1'b1;
        queue_word(w);
      end
      return;
    end
    diff = shadow_store[idx] ^ now;
    left = $countones(diff);
    for (int b = 0; b < bcd_pkg::BYTE_W; b++) begin
      if (diff[b]) begin
        left--;
        if (shadow_count != bcd_pkg::CNT_MAX) shadow_count++;
        w = '0;
        w.kind = bcd_pkg::KIND_CHANGE;
        w.bit_index = {idx, bcd_pkg::BIT_W'(b)};
        w.old_bit = shadow_store[idx][b];
        w.new_bit = now[b];
        w.change_count = shadow_count;
        w.last_result = (left == 0) && (idx != span - 1);
        queue_word(w);
      end
    end
    shadow_store[idx] = now;
    if (idx == span - 1) begin
      w = '0;
      w.kind = bcd_pkg::KIND_SUMMARY;
      w.change_count = shadow_count;
      w.last_result = 1'b1;
      queue_word(w);
      shadow_count = '0;
    end
  endtask

  // driver: hold the word while stalled, advance from the feed otherwise
  always @(posedge clk) begin
    snap_byte_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall)
        predict_bit_changes(command, byte_index, data_byte);
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (byte_feed.size() != 0) begin
          nxt = byte_feed.pop_front();
          command <= nxt.cmd;
          byte_index <= nxt.idx;
          data_byte <= nxt.data;
          in_valid <= 1'b1;
          gap_left = (!calm && $urandom_range(0, 9) < 4) ? pick_idle() : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: check each accepted word against the oldest prediction
  always @(posedge clk) begin
    change_word_t want;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        words_checked++;
        if (kind === bcd_pkg::KIND_SUMMARY) begin
          summaries_seen++;
          if (int'(change_count) > top_total) top_total = int'(change_count);
        end
        if (predicted_words.size() == 0) begin
          report_mismatch($sformatf("unexpected word kind=%0d bit_index=%0d count=%0d",
                                    kind, bit_index, change_count));
        end else begin
          want = predicted_words.pop_front();
          if (kind !== want.kind)
            report_mismatch($sformatf("kind %0d, want %0d", kind, want.kind));
          if (bit_index !== want.bit_index)
            report_mismatch($sformatf("bit_index %0d, want %0d", bit_index, want.bit_index));
          if (old_bit !== want.old_bit)
            report_mismatch($sformatf("old_bit %0d, want %0d at bit %0d",
                                      old_bit, want.old_bit, want.bit_index));
          if (new_bit !== want.new_bit)
            report_mismatch($sformatf("new_bit %0d, want %0d at bit %0d",
                                      new_bit, want.new_bit, want.bit_index));
          if (change_count !== want.change_count)
            report_mismatch($sformatf("change_count %0d, want %0d",
                                      change_count, want.change_count));
          if (last_result !== want.last_result)
            report_mismatch($sformatf("last_result %0d, want %0d",
                                      last_result, want.last_result));
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 9) < 3) begin
        stall_left = pick_idle() - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("ERROR: timeout after %0d cycles, %0d words still expected",
               cycles, predicted_words.size());
      $display("bit_change_detector: mismatch");
      $finish;
    end
  end

  task automatic settle();
    do @(negedge clk);
    while (byte_feed.size() != 0 || in_valid || predicted_words.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_length(input int v);
    settle();
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data <= bcd_pkg::LEN_W'(v);
    @(posedge clk);
    cfg_write <= 1'b0;
    cur_len = bcd_pkg::LEN_W'(v);
    len_writes++;
  endtask

  // queue a byte; a compare of a never-written entry turns into a rebaseline
  task automatic feed_byte(input bit cmd, input int idx,
                           input bit [bcd_pkg::BYTE_W-1:0] data);
    snap_byte_t b;
    int         span;
    span = clamp_len(cur_len);
    if (idx < span) begin
      if (cmd == bcd_pkg::CMD_COMPARE && feed_baseline && !feed_written[idx])
        cmd = bcd_pkg::CMD_REBASE;
      if (cmd == bcd_pkg::CMD_REBASE || !feed_baseline) begin
        feed_written[idx] = 1'b1;
        if (idx == span - 1) feed_baseline = 1'b1;
      end
      feed_value[idx] = data;
      useful_sent++;
    end
    b.cmd = cmd;
    b.idx = bcd_pkg::IDX_W'(idx);
    b.data = data;
    byte_feed = {byte_feed, b};
  endtask

  task automatic feed_pass(input bit cmd);
    int span;
    span = clamp_len(cur_len);
    for (int i = 0; i < span; i++)
      feed_byte(cmd, i, nudge_byte(feed_value[i]));
  endtask

  task automatic feed_noise(input int n);
    int span;
    int r;
    int idx;
    span = clamp_len(cur_len);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 9);
      if (r < 5) idx = $urandom_range(0, span + 2);
      else if (r < 7) idx = $urandom_range(0, STORE_DEPTH - 1);
      else idx = $urandom_range(0, span - 1);
      feed_byte(($urandom_range(0, 3) == 0) ? bcd_pkg::CMD_REBASE : bcd_pkg::CMD_COMPARE,
                idx,
                (idx < STORE_DEPTH) ? nudge_byte(feed_value[idx])
                                    : bcd_pkg::BYTE_W'($urandom));
    end
  endtask

  task automatic feed_sparse();
    int idx;
    repeat ($urandom_range(1, 4)) begin
      idx = $urandom_range(0, 1) ? $urandom_range(0, 11) : $urandom_range(0, STORE_DEPTH - 2);
      feed_byte(($urandom_range(0, 4) == 0) ? bcd_pkg::CMD_REBASE : bcd_pkg::CMD_COMPARE,
                idx, nudge_byte(feed_value[idx]));
    end
    feed_byte(bcd_pkg::CMD_COMPARE, STORE_DEPTH - 1,
              nudge_byte(feed_value[STORE_DEPTH - 1]));
  endtask

  initial begin
    int target;
    int pick;
    int span;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    command = bcd_pkg::CMD_COMPARE;
    byte_index = '0;
    data_byte = '0;
    out_stall = 1'b0;
    calm = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset length: baseline on the top byte, full flips at both ends of the index range
    feed_byte(bcd_pkg::CMD_REBASE, 0, 8'h00);
    feed_byte(bcd_pkg::CMD_COMPARE, STORE_DEPTH - 1, 8'h00);
    feed_byte(bcd_pkg::CMD_COMPARE, STORE_DEPTH - 1, 8'hFF);
    feed_byte(bcd_pkg::CMD_COMPARE, 0, 8'hFF);
    feed_byte(bcd_pkg::CMD_COMPARE, 0, 8'hFF);
    feed_byte(bcd_pkg::CMD_REBASE, STORE_DEPTH - 1, 8'h5A);
    feed_byte(bcd_pkg::CMD_COMPARE, 0, 8'h00);
    feed_byte(bcd_pkg::CMD_COMPARE, STORE_DEPTH - 1, 8'hA5);

    set_length(0);
    feed_byte(bcd_pkg::CMD_COMPARE, 0, 8'h81);
    feed_byte(bcd_pkg::CMD_COMPARE, 1, 8'h7E);
    feed_byte(bcd_pkg::CMD_COMPARE, STORE_DEPTH - 1, 8'hC3);
    feed_byte(bcd_pkg::CMD_REBASE, 0, 8'h3C);

    set_length(3);
    feed_byte(bcd_pkg::CMD_COMPARE, 3, 8'h55);
    feed_pass(bcd_pkg::CMD_COMPARE);
    feed_pass(bcd_pkg::CMD_REBASE);
    feed_byte(bcd_pkg::CMD_COMPARE, 0, 8'hAA);
    feed_byte(bcd_pkg::CMD_REBASE, 1, 8'h0F);
    feed_byte(bcd_pkg::CMD_COMPARE, 2, 8'hF0);

    set_length(8191);
    feed_byte(bcd_pkg::CMD_COMPARE, STORE_DEPTH - 1, 8'h96);
    set_length(4097);
    feed_byte(bcd_pkg::CMD_COMPARE, 0, 8'h69);
    feed_byte(bcd_pkg::CMD_COMPARE, STORE_DEPTH - 1, 8'h00);
    set_length(1);
    feed_byte(bcd_pkg::CMD_COMPARE, 0, 8'hFF);

    target = useful_sent + RANDOM_ITEMS;
    while (useful_sent < target) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) set_length(0);
      else if (pick == 1) set_length($urandom_range(STORE_DEPTH, 8191));
      else if (pick == 2) set_length(STORE_DEPTH);
      else set_length($urandom_range(1, 12));
      calm = ($urandom_range(0, 3) == 0);
      span = clamp_len(cur_len);
      repeat ($urandom_range(1, 4)) begin
        if (span > 16) feed_sparse();
        else if ($urandom_range(0, 9) < 7)
          feed_pass(($urandom_range(0, 4) == 0) ? bcd_pkg::CMD_REBASE : bcd_pkg::CMD_COMPARE);
        else feed_noise($urandom_range(1, 6));
      end
    end
    settle();

    $display("Run covered %0d snapshot bytes over %0d length settings.",
             useful_sent, len_writes);
    $display("Checked %0d result words, %0d of them summaries, highest pass total %0d.",
             words_checked, summaries_seen, top_total);
    if (mismatches == 0)
      $display("bit_change_detector: match");
    else
      $display("bit_change_detector: mismatch");
    $finish;
  end

endmodule
